### design/isg_pkg.sv
`timescale 1ns / 1ps

package isg_pkg;

	// destination scope codes
	typedef enum logic [2:0] {
		SCOPE_PUBLIC      = 3'd0,
		SCOPE_LOOPBACK    = 3'd1,
		SCOPE_PRIVATE     = 3'd2,
		SCOPE_LINKLOCAL   = 3'd3,
		SCOPE_CGNAT       = 3'd4,
		SCOPE_RESERVED    = 3'd5,
		SCOPE_MULTICAST   = 3'd6,
		SCOPE_UNSPECIFIED = 3'd7
	} scope_t;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_ISOLATE_ENABLE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALLOW_LOOPBACK = 8'd1;

	// well-known IPv6 prefixes
	localparam logic [63:0] NAT64_HIGH    = 64'h0064_ff9b_0000_0000;
	localparam logic [15:0] SIX_TO_FOUR   = 16'h2002;
	localparam logic [31:0] MAPPED_MARK   = 32'h0000_ffff;

endpackage

### design/ip_scope_guard.sv
`timescale 1ns / 1ps

// Destination scope guard. Each transaction carries one IPv4 or IPv6 address
// and returns its scope and whether isolation refuses it. IPv6 forms that
// embed an IPv4 address (mapped, compatible, NAT64, 6to4) are classified by
// the IPv4 rules. The block runs as a three-stage pipeline: IPv6 prefix
// decode and IPv4 extraction, IPv4 range classification, then the block
// decision in the output register. It accepts one address per cycle and a
// result is registered in each stage in turn; out_ready low holds the
// pipeline, and in_ready drops only once all three stages are full.
// Configuration (cfg_we, cfg_index, cfg_wdata) is meant to be written only
// while no transaction is in flight.
module ip_scope_guard (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [isg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic                            cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            is_ipv6,
	input  logic [63:0]                     addr_high,
	input  logic [63:0]                     addr_low,
	output logic                            out_valid,
	input  logic                            out_ready,
	output isg_pkg::scope_t                 scope,
	output logic                            blocked
);
	import isg_pkg::*;

	logic isolate_enable_q;
	logic allow_loopback_q;

	logic        valid_s1, valid_s2, valid_s3;
	logic        en1, en2, en3;

	logic        use_v4_s1;
	logic [31:0] v4_addr_s1;
	scope_t      fixed_scope_s1;

	scope_t      scope_s2;
	scope_t      scope_s3;
	logic        blocked_s3;

	logic        use_v4_d;
	logic [31:0] v4_addr_d;
	scope_t      fixed_scope_d;
	scope_t      v4_scope;
	scope_t      scope_d2;
	logic        blocked_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isolate_enable_q <= 1'b1;
			allow_loopback_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_ISOLATE_ENABLE) isolate_enable_q <= cfg_wdata;
			if (cfg_index == REG_ALLOW_LOOPBACK) allow_loopback_q <= cfg_wdata;
		end
	end

	// stage enables: a stage loads when it is empty or its successor moves
	assign en3      = !valid_s3 || out_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: IPv6 prefix decode, pick the IPv4 address to classify
	always_comb begin
		logic hi_zero;
		logic lo_top_zero;
		hi_zero       = (addr_high == 64'd0);
		lo_top_zero   = (addr_low[63:32] == 32'd0);
		use_v4_d      = 1'b1;
		v4_addr_d     = addr_low[31:0];
		fixed_scope_d = SCOPE_PUBLIC;
		if (is_ipv6) begin
			priority if (hi_zero && addr_low[63:32] == MAPPED_MARK) begin
				use_v4_d = 1'b1;
			end else if (hi_zero && addr_low == 64'd1) begin
				use_v4_d      = 1'b0;
				fixed_scope_d = SCOPE_LOOPBACK;
			end else if (hi_zero && addr_low == 64'd0) begin
				use_v4_d      = 1'b0;
				fixed_scope_d = SCOPE_UNSPECIFIED;
			end else if (hi_zero && lo_top_zero) begin
				use_v4_d = 1'b1;
			end else if (addr_high == NAT64_HIGH && lo_top_zero) begin
				use_v4_d = 1'b1;
			end else if (addr_high[63:48] == SIX_TO_FOUR) begin
				use_v4_d  = 1'b1;
				v4_addr_d = addr_high[47:16];
			end else if (addr_high[63:57] == 7'b1111_110) begin
				use_v4_d      = 1'b0;
				fixed_scope_d = SCOPE_PRIVATE;
			end else if (addr_high[63:56] == 8'hfe && addr_high[55:54] == 2'b10) begin
				use_v4_d      = 1'b0;
				fixed_scope_d = SCOPE_LINKLOCAL;
			end else if (addr_high[63:56] == 8'hff) begin
				use_v4_d      = 1'b0;
				fixed_scope_d = SCOPE_MULTICAST;
			end else begin
				use_v4_d      = 1'b0;
				fixed_scope_d = SCOPE_PUBLIC;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			use_v4_s1      <= use_v4_d;
			v4_addr_s1     <= v4_addr_d;
			fixed_scope_s1 <= fixed_scope_d;
		end
	end

	// stage 2: IPv4 special-use ranges
	always_comb begin
		logic [7:0] o1, o2, o3;
		o1 = v4_addr_s1[31:24];
		o2 = v4_addr_s1[23:16];
		o3 = v4_addr_s1[15:8];
		priority if (o1 == 8'd0)                                v4_scope = SCOPE_RESERVED;
		else if (o1 == 8'd10)                                   v4_scope = SCOPE_PRIVATE;
		else if (o1 == 8'd100 && o2[7:6] == 2'b01)              v4_scope = SCOPE_CGNAT;
		else if (o1 == 8'd127)                                  v4_scope = SCOPE_LOOPBACK;
		else if (o1 == 8'd169 && o2 == 8'd254)                  v4_scope = SCOPE_LINKLOCAL;
		else if (o1 == 8'd172 && o2[7:4] == 4'd1)               v4_scope = SCOPE_PRIVATE;
		else if (o1 == 8'd192 && o2 == 8'd168)                  v4_scope = SCOPE_PRIVATE;
		else if (o1 == 8'd192 && o2 == 8'd0 && (o3 == 8'd0 || o3 == 8'd2))
			v4_scope = SCOPE_RESERVED;
		else if (o1 == 8'd192 && o2 == 8'd88 && o3 == 8'd99)    v4_scope = SCOPE_RESERVED;
		else if (o1 == 8'd198 && o2[7:1] == 7'd9)               v4_scope = SCOPE_RESERVED;
		else if (o1 == 8'd198 && o2 == 8'd51 && o3 == 8'd100)   v4_scope = SCOPE_RESERVED;
		else if (o1 == 8'd203 && o2 == 8'd0 && o3 == 8'd113)    v4_scope = SCOPE_RESERVED;
		else if (o1[7:4] == 4'he)                               v4_scope = SCOPE_MULTICAST;
		else if (o1[7:4] == 4'hf)                               v4_scope = SCOPE_RESERVED;
		else                                                    v4_scope = SCOPE_PUBLIC;
	end

	assign scope_d2 = use_v4_s1 ? v4_scope : fixed_scope_s1;

	always_ff @(posedge clk) begin
		if (en2) scope_s2 <= scope_d2;
	end

	// stage 3: isolation decision into the output register
	assign blocked_d = isolate_enable_q && (scope_s2 != SCOPE_PUBLIC) &&
		!(scope_s2 == SCOPE_LOOPBACK && allow_loopback_q);

	always_ff @(posedge clk) begin
		if (en3) begin
			scope_s3   <= scope_s2;
			blocked_s3 <= blocked_d;
		end
	end

	assign out_valid = valid_s3;
	assign scope     = scope_s3;
	assign blocked   = blocked_s3;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import isg_pkg::*;

	localparam int IDLE_PCT       = 38;
	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 250;

	typedef struct packed {
		logic        v6;
		logic [63:0] hi;
		logic [63:0] lo;
	} addr_item_t;

	typedef struct {
		scope_t scope;
		logic   blocked;
	} verdict_t;

	// block ports, inputs all known from time zero
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic                   cfg_wdata = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic                   is_ipv6   = 1'b0;
	logic [63:0]            addr_high = '0;
	logic [63:0]            addr_low  = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	scope_t                 scope;
	logic                   blocked;

	// guard settings as the predictor sees them
	logic isolate_on = 1'b1;
	logic loopback_ok = 1'b0;

	// one phase runs with both sides never idling
	logic steady = 1'b0;

	addr_item_t addr_backlog[$];
	verdict_t   verdicts_due[$];

	int unsigned mismatches     = 0;
	int unsigned verdicts_seen  = 0;
	int unsigned v6_sent        = 0;
	int unsigned settings_run   = 0;
	int unsigned stalls_applied = 0;

	ip_scope_guard i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.is_ipv6   (is_ipv6),
		.addr_high (addr_high),
		.addr_low  (addr_low),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scope     (scope),
		.blocked   (blocked)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// IPv4 range rules
	function automatic scope_t v4_scope(input logic [31:0] a);
		logic [7:0] o1;
		logic [7:0] o2;
		logic [7:0] o3;
		o1 = a[31:24];
		o2 = a[23:16];
		o3 = a[15:8];
		if (o1 == 8'd0) return SCOPE_RESERVED;
		if (o1 == 8'd10) return SCOPE_PRIVATE;
		if (o1 == 8'd100 && o2 >= 8'd64 && o2 <= 8'd127) return SCOPE_CGNAT;
		if (o1 == 8'd127) return SCOPE_LOOPBACK;
		if (o1 == 8'd169 && o2 == 8'd254) return SCOPE_LINKLOCAL;
		if (o1 == 8'd172 && o2 >= 8'd16 && o2 <= 8'd31) return SCOPE_PRIVATE;
		if (o1 == 8'd192 && o2 == 8'd168) return SCOPE_PRIVATE;
		if (o1 == 8'd192 && o2 == 8'd0 && (o3 == 8'd0 || o3 == 8'd2)) return SCOPE_RESERVED;
		if (o1 == 8'd192 && o2 == 8'd88 && o3 == 8'd99) return SCOPE_RESERVED;
		if (o1 == 8'd198 && (o2 == 8'd18 || o2 == 8'd19)) return SCOPE_RESERVED;
		if (o1 == 8'd198 && o2 == 8'd51 && o3 == 8'd100) return SCOPE_RESERVED;
		if (o1 == 8'd203 && o2 == 8'd0 && o3 == 8'd113) return SCOPE_RESERVED;
		if (o1 >= 8'd224 && o1 <= 8'd239) return SCOPE_MULTICAST;
		if (o1 >= 8'd240) return SCOPE_RESERVED;
		return SCOPE_PUBLIC;
	endfunction

	// IPv6 prefix decode, order matters
	function automatic scope_t v6_scope(input logic [63:0] hi, input logic [63:0] lo);
		if (hi == 64'd0 && lo[63:32] == MAPPED_MARK) return v4_scope(lo[31:0]);
		if (hi == 64'd0 && lo == 64'd1) return SCOPE_LOOPBACK;
		if (hi == 64'd0 && lo == 64'd0) return SCOPE_UNSPECIFIED;
		if (hi == 64'd0 && lo[63:32] == 32'd0) return v4_scope(lo[31:0]);
		if (hi == NAT64_HIGH && lo[63:32] == 32'd0) return v4_scope(lo[31:0]);
		if (hi[63:48] == SIX_TO_FOUR) return v4_scope(hi[47:16]);
		if (hi[63:57] == 7'b1111110) return SCOPE_PRIVATE;
		if (hi[63:56] == 8'hfe && hi[55:54] == 2'b10) return SCOPE_LINKLOCAL;
		if (hi[63:56] == 8'hff) return SCOPE_MULTICAST;
		return SCOPE_PUBLIC;
	endfunction

	function automatic verdict_t classify(input addr_item_t it);
		verdict_t v;
		v.scope   = it.v6 ? v6_scope(it.hi, it.lo) : v4_scope(it.lo[31:0]);
		v.blocked = isolate_on && v.scope != SCOPE_PUBLIC &&
			!(v.scope == SCOPE_LOOPBACK && loopback_ok);
		return v;
	endfunction

	// IPv4 address biased toward range edges
	function automatic logic [31:0] pick_v4();
		logic [7:0] o1;
		logic [7:0] o2;
		logic [7:0] o3;
		case ($urandom_range(15))
			0: o1 = 8'd0;
			1: o1 = 8'd10;
			2: o1 = 8'd100;
			3: o1 = 8'd127;
			4: o1 = 8'd169;
			5: o1 = 8'd172;
			6, 7: o1 = 8'd192;
			8: o1 = 8'd198;
			9: o1 = 8'd203;
			10: o1 = 8'($urandom_range(239, 224));
			11: o1 = 8'($urandom_range(255, 240));
			12: o1 = 8'd223;
			default: o1 = 8'($urandom);
		endcase
		case ($urandom_range(21))
			0: o2 = 8'd0;
			1: o2 = 8'd15;
			2: o2 = 8'd16;
			3: o2 = 8'd18;
			4: o2 = 8'd19;
			5: o2 = 8'd31;
			6: o2 = 8'd32;
			7: o2 = 8'd51;
			8: o2 = 8'd63;
			9: o2 = 8'd64;
			10: o2 = 8'd88;
			11: o2 = 8'd127;
			12: o2 = 8'd128;
			13: o2 = 8'd168;
			14: o2 = 8'd254;
			15: o2 = 8'd255;
			default: o2 = 8'($urandom);
		endcase
		case ($urandom_range(12))
			0: o3 = 8'd0;
			1: o3 = 8'd1;
			2: o3 = 8'd2;
			3: o3 = 8'd3;
			4: o3 = 8'd99;
			5: o3 = 8'd100;
			6: o3 = 8'd112;
			7: o3 = 8'd113;
			8: o3 = 8'd114;
			default: o3 = 8'($urandom);
		endcase
		return {o1, o2, o3, 8'($urandom)};
	endfunction

	// mostly well-formed addresses in every form, some near misses and noise
	function automatic addr_item_t make_addr();
		addr_item_t it;
		int unsigned k;
		int unsigned flip;
		k     = $urandom_range(99);
		it.v6 = 1'b1;
		it.hi = {$urandom, $urandom};
		it.lo = {$urandom, $urandom};
		if (k < 35) begin
			it.v6 = 1'b0;
			it.lo[31:0] = pick_v4();
		end else if (k < 45) begin
			it.hi = '0;
			it.lo = {MAPPED_MARK, pick_v4()};
		end else if (k < 52) begin
			it.hi = '0;
			it.lo = {32'd0, pick_v4()};
		end else if (k < 59) begin
			it.hi = NAT64_HIGH;
			it.lo = {32'd0, pick_v4()};
		end else if (k < 66) begin
			it.hi[63:16] = {SIX_TO_FOUR, pick_v4()};
		end else if (k < 70) begin
			it.hi[63:57] = 7'b1111110;
		end else if (k < 75) begin
			it.hi[63:56] = 8'hfe;
			if ($urandom_range(1)) it.hi[55:54] = 2'b10;
		end else if (k < 79) begin
			it.hi[63:56] = 8'hff;
		end else if (k < 81) begin
			it.hi = '0;
			it.lo = 64'($urandom_range(1));
		end else if (k < 88) begin
			// one bit flipped in an embedding prefix or its embedded IPv4 address
			it.hi = $urandom_range(1) ? NAT64_HIGH : 64'd0;
			it.lo = {$urandom_range(1) ? MAPPED_MARK : 32'd0, pick_v4()};
			flip  = $urandom_range(127);
			if (flip < 64) it.hi[flip] = ~it.hi[flip];
			else it.lo[flip-64] = ~it.lo[flip-64];
		end
		return it;
	endfunction

	task automatic queue_v4(input logic [31:0] a);
		addr_backlog.push_back({1'b0, {$urandom, $urandom}, {$urandom, a}});
	endtask

	task automatic queue_v6(input logic [63:0] hi, input logic [63:0] lo);
		addr_backlog.push_back({1'b1, hi, lo});
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (addr_backlog.size() != 0 || in_valid || verdicts_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ISOLATE_ENABLE) isolate_on = val;
		else if (idx == REG_ALLOW_LOOPBACK) loopback_ok = val;
	endtask

	// driver: present backlog items, record the expected verdict on acceptance
	always @(posedge clk or negedge arst_n) begin : drive_proc
		addr_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				verdicts_due.push_back(classify({is_ipv6, addr_high, addr_low}));
				if (is_ipv6) v6_sent++;
			end
			if (!in_valid || in_ready) begin
				if (addr_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					it = addr_backlog.pop_front();
					in_valid  <= 1'b1;
					is_ipv6   <= it.v6;
					addr_high <= it.hi;
					addr_low  <= it.lo;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, compare each result transaction in order
	always @(posedge clk or negedge arst_n) begin : watch_proc
		verdict_t due;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				verdicts_seen++;
				if (verdicts_due.size() == 0) begin
					$error("unexpected result: scope %0d blocked %0d", scope, blocked);
					mismatches++;
				end else begin
					due = verdicts_due.pop_front();
					if (scope !== due.scope) begin
						$error("scope: expected %0d, got %0d", due.scope, scope);
						mismatches++;
					end
					if (blocked !== due.blocked) begin
						$error("blocked: expected %0d, got %0d", due.blocked, blocked);
						mismatches++;
					end
				end
			end
			if (out_valid && !out_ready) stalls_applied++;
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin : stimulus_proc
		int p;
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, range edges and IPv6 precedence
		settings_run++;
		queue_v4(32'h0000_0000);
		addr_backlog[$].hi = '1;
		addr_backlog[$].lo[63:32] = '1;
		queue_v4(32'hffff_ffff);
		queue_v4(32'h6440_0000);
		queue_v4(32'h647f_ffff);
		queue_v4(32'h7f00_0001);
		queue_v4(32'ha9fe_0001);
		queue_v4(32'hac1f_ffff);
		queue_v4(32'hc000_0201);
		queue_v4(32'hc058_6301);
		queue_v4(32'hc633_6401);
		queue_v4(32'hcb00_7101);
		queue_v4(32'he000_0001);
		queue_v4(32'h0808_0808);
		queue_v6(64'd0, {MAPPED_MARK, 32'h0a00_0001});
		queue_v6(64'd0, {MAPPED_MARK, 32'h0000_0000});
		queue_v6(64'd0, 64'd1);
		queue_v6(64'd0, 64'd0);
		queue_v6(64'd0, 64'h0000_0000_7f00_0001);
		queue_v6(64'd0, 64'd2);
		queue_v6(NAT64_HIGH, 64'h0000_0000_c0a8_0001);
		queue_v6({SIX_TO_FOUR, 32'hc0a8_0101, 16'h0000}, 64'd0);
		queue_v6(64'hfd00_0000_0000_0000, 64'd1);
		queue_v6(64'hfe80_0000_0000_0000, 64'd1);
		queue_v6(64'hfebf_ffff_ffff_ffff, '1);
		queue_v6(64'hff02_0000_0000_0000, 64'd1);
		queue_v6(64'h2001_0db8_0000_0000, 64'd1);
		queue_v6('1, '1);
		wait_drained();

		// random phases over every guard setting
		for (p = 0; p < PHASES; p++) begin
			write_reg(REG_ISOLATE_ENABLE, !p[1]);
			write_reg(REG_ALLOW_LOOPBACK, p[0]);
			// out-of-range index must leave both settings alone
			write_reg(CFG_INDEX_W'($urandom_range(255, 2)), 1'($urandom));
			settings_run++;
			@(negedge clk);
			steady = (p == 3);
			for (n = 0; n < ITEMS_PER_PHASE; n++) addr_backlog.push_back(make_addr());
			wait_drained();
			steady = 1'b0;
		end

		repeat (8) @(negedge clk);
		$display("tb_top: %0d verdicts checked (%0d IPv6) over %0d guard settings",
			verdicts_seen, v6_sent, settings_run);
		$display("tb_top: %0d cycles of output back-pressure, %0d mismatches",
			stalls_applied, mismatches);
		if (mismatches == 0 && verdicts_due.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	// run limit
	initial begin : watchdog_proc
		#5_000_000;
		$display("tb_top: run limit reached, %0d verdicts outstanding", verdicts_due.size());
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
